>>> hdl/isp_pkg.sv
package isp_pkg;

   localparam int FRAME_BYTES = 4;

   typedef logic [3:0] opcode_type;
   typedef logic [1:0] action_type;
   typedef logic [1:0] status_type;
   typedef logic [2:0] phase_type;
   typedef logic [1:0] reg_index_type;
   typedef logic [9:0] ticks_type;

   localparam opcode_type OP_RESET       = 4'd0;
   localparam opcode_type OP_ENABLE      = 4'd1;
   localparam opcode_type OP_SIGNATURE   = 4'd2;
   localparam opcode_type OP_ERASE       = 4'd3;
   localparam opcode_type OP_FLASH_READ  = 4'd4;
   localparam opcode_type OP_FLASH_LOAD  = 4'd5;
   localparam opcode_type OP_PAGE_WRITE  = 4'd6;
   localparam opcode_type OP_EEPROM_READ = 4'd7;
   localparam opcode_type OP_EEPROM_WRITE = 4'd8;
   localparam opcode_type OP_BYTE_RX     = 4'd9;
   localparam opcode_type OP_TICK        = 4'd10;

   localparam action_type ACT_SEND = 2'd0;
   localparam action_type ACT_PIN  = 2'd1;
   localparam action_type ACT_DONE = 2'd2;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FAIL   = 2'd1;
   localparam status_type ST_REJECT = 2'd2;

   localparam phase_type PH_IDLE      = 3'd0;
   localparam phase_type PH_RESET_LOW = 3'd1;
   localparam phase_type PH_EN_PULSE  = 3'd2;
   localparam phase_type PH_EN_SETTLE = 3'd3;
   localparam phase_type PH_XFER      = 3'd4;

   localparam reg_index_type REG_RESET_PULSE = 2'd0;
   localparam reg_index_type REG_SETTLE      = 2'd1;
   localparam reg_index_type REG_ATTEMPTS    = 2'd2;

   localparam ticks_type    RESET_PULSE_DEFAULT = 10'd5;
   localparam ticks_type    SETTLE_DEFAULT      = 10'd81;
   localparam logic [7:0]   ATTEMPTS_DEFAULT    = 8'd20;

   localparam logic [7:0] CMD_PROG    = 8'hac;
   localparam logic [7:0] CMD_ENABLE2 = 8'h53;
   localparam logic [7:0] CMD_POLL    = 8'hf0;
   localparam logic [7:0] CMD_SIG     = 8'h30;
   localparam logic [7:0] CMD_RD_HI   = 8'h28;
   localparam logic [7:0] CMD_RD_LO   = 8'h20;
   localparam logic [7:0] CMD_LD_HI   = 8'h48;
   localparam logic [7:0] CMD_LD_LO   = 8'h40;
   localparam logic [7:0] CMD_PAGE    = 8'h4c;
   localparam logic [7:0] CMD_EE_RD   = 8'ha0;
   localparam logic [7:0] CMD_EE_WR   = 8'hc0;
   localparam logic [7:0] CMD_ERASE2  = 8'h80;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      action_type action;
      logic [7:0] tx_byte;
      logic       reset_level;
      logic [7:0] read_data;
      status_type status;
      logic       programming_enabled;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      ticks_type  reset_pulse_ticks;
      ticks_type  settle_ticks;
      logic [7:0] enable_attempts;
   } cfg_type;

   function automatic rsp_type make_rsp(action_type act, logic [7:0] tx, logic lvl,
                                        logic [7:0] rd, status_type st);
      rsp_type r;
      r.action              = act;
      r.tx_byte             = tx;
      r.reset_level         = lvl;
      r.read_data           = rd;
      r.status              = st;
      r.programming_enabled = 1'b0;
      r.last                = 1'b0;
      return r;
   endfunction

   // base-4 digit sum, then fold
   function automatic logic [1:0] mod3(logic [7:0] x);
      logic [3:0] s;
      logic [2:0] v;
      logic [2:0] w;
      s = 4'(x[7:6]) + 4'(x[5:4]) + 4'(x[3:2]) + 4'(x[1:0]);
      v = 3'(s[3:2]) + 3'(s[1:0]);
      if (v >= 3'd6) begin
         w = v - 3'd6;
      end else if (v >= 3'd3) begin
         w = v - 3'd3;
      end else begin
         w = v;
      end
      return w[1:0];
   endfunction

endpackage

>>> hdl/isp_if.sv
interface isp_req_if;
   logic                  valid;
   logic                  ready;
   isp_pkg::opcode_type   opcode;
   logic [15:0]           address;
   logic [7:0]            write_data;
   logic [7:0]            rx_byte;
   modport source(output valid, opcode, address, write_data, rx_byte, input ready);
   modport sink(input valid, opcode, address, write_data, rx_byte, output ready);
endinterface

interface isp_rsp_if;
   logic                  valid;
   logic                  ready;
   isp_pkg::action_type   action;
   logic [7:0]            tx_byte;
   logic                  reset_level;
   logic [7:0]            read_data;
   isp_pkg::status_type   status;
   logic                  programming_enabled;
   logic                  last;
   modport source(output valid, action, tx_byte, reset_level, read_data, status,
                  programming_enabled, last, input ready);
   modport sink(input valid, action, tx_byte, reset_level, read_data, status,
                programming_enabled, last, output ready);
endinterface

interface isp_csr_if;
   logic                    valid;
   logic                    ready;
   isp_pkg::reg_index_type  reg_index;
   logic [9:0]              reg_data;
   modport source(output valid, reg_index, reg_data, input ready);
   modport sink(input valid, reg_index, reg_data, output ready);
endinterface

>>> hdl/isp_seq_core.sv
module isp_seq_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  isp_pkg::req_type  item,
   input  isp_pkg::cfg_type  cfg,
   output isp_pkg::push_type push
);

   logic                busy_ff, busy_in;
   isp_pkg::phase_type  phase_ff, phase_in;
   isp_pkg::opcode_type cmd_ff, cmd_in;
   logic [7:0]          frame_ff [isp_pkg::FRAME_BYTES];
   logic [7:0]          frame_in [isp_pkg::FRAME_BYTES];
   logic [1:0]          idx_ff, idx_in;
   logic [7:0]          echo_ff, echo_in;
   logic [7:0]          attempt_ff, attempt_in;
   isp_pkg::ticks_type  tick_ff, tick_in;
   logic                polling_ff, polling_in;
   logic                enabled_ff, enabled_in;

   logic [14:0]         half;
   logic [7:0]          attempt_nx;
   logic [7:0]          limit;
   isp_pkg::rsp_type    r0, r1;
   logic [1:0]          cnt;
   logic                in_wait;

   assign half       = item.address[15:1];
   assign attempt_nx = (attempt_ff < 8'd255) ? attempt_ff + 8'd1 : attempt_ff;
   assign limit      = (cfg.enable_attempts == 8'd0) ? 8'd1 : cfg.enable_attempts;
   assign in_wait    = (phase_ff == isp_pkg::PH_RESET_LOW) ||
                       (phase_ff == isp_pkg::PH_EN_PULSE) ||
                       (phase_ff == isp_pkg::PH_EN_SETTLE);

   always_comb begin
      busy_in    = busy_ff;
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      frame_in   = frame_ff;
      idx_in     = idx_ff;
      echo_in    = echo_ff;
      attempt_in = attempt_ff;
      tick_in    = tick_ff;
      polling_in = polling_ff;
      enabled_in = enabled_ff;
      r0 = isp_pkg::make_rsp(isp_pkg::ACT_SEND, 8'd0, 1'b0, 8'd0, isp_pkg::ST_OK);
      r1 = r0;
      cnt = 2'd0;
      if (go) begin
         if (item.opcode <= isp_pkg::OP_EEPROM_WRITE) begin
            if (busy_ff) begin
               r0 = isp_pkg::make_rsp(isp_pkg::ACT_DONE, 8'd0, 1'b0, 8'd0,
                                      isp_pkg::ST_REJECT);
               cnt = 2'd1;
            end else begin
               busy_in    = 1'b1;
               cmd_in     = item.opcode;
               polling_in = 1'b0;
               phase_in   = isp_pkg::PH_XFER;
               idx_in     = 2'd0;
               frame_in[1] = 8'd0;
               frame_in[2] = 8'd0;
               frame_in[3] = 8'd0;
               case (item.opcode)
                  isp_pkg::OP_RESET: begin
                     frame_in   = frame_ff;
                     idx_in     = idx_ff;
                     phase_in   = isp_pkg::PH_RESET_LOW;
                     tick_in    = cfg.reset_pulse_ticks;
                  end
                  isp_pkg::OP_ENABLE: begin
                     frame_in   = frame_ff;
                     idx_in     = idx_ff;
                     attempt_in = 8'd0;
                     phase_in   = isp_pkg::PH_EN_PULSE;
                     tick_in    = cfg.reset_pulse_ticks;
                  end
                  isp_pkg::OP_SIGNATURE: begin
                     frame_in[0] = isp_pkg::CMD_SIG;
                     frame_in[2] = {6'd0, isp_pkg::mod3(item.address[7:0])};
                  end
                  isp_pkg::OP_ERASE: begin
                     frame_in[0] = isp_pkg::CMD_PROG;
                     frame_in[1] = isp_pkg::CMD_ERASE2;
                  end
                  isp_pkg::OP_FLASH_READ: begin
                     frame_in[0] = item.address[0] ? isp_pkg::CMD_RD_HI : isp_pkg::CMD_RD_LO;
                     frame_in[1] = {1'b0, half[14:8]};
                     frame_in[2] = half[7:0];
                  end
                  isp_pkg::OP_FLASH_LOAD: begin
                     frame_in[0] = item.address[0] ? isp_pkg::CMD_LD_HI : isp_pkg::CMD_LD_LO;
                     frame_in[1] = {1'b0, half[14:8]};
                     frame_in[2] = half[7:0];
                     frame_in[3] = item.write_data;
                  end
                  isp_pkg::OP_PAGE_WRITE: begin
                     frame_in[0] = isp_pkg::CMD_PAGE;
                     frame_in[1] = {1'b0, half[14:8]};
                     frame_in[2] = half[7:0];
                  end
                  isp_pkg::OP_EEPROM_READ: begin
                     frame_in[0] = isp_pkg::CMD_EE_RD;
                     frame_in[2] = item.address[7:0];
                  end
                  default: begin
                     frame_in[0] = isp_pkg::CMD_EE_WR;
                     frame_in[2] = item.address[7:0];
                     frame_in[3] = item.write_data;
                  end
               endcase
               if (item.opcode == isp_pkg::OP_RESET) begin
                  r0 = isp_pkg::make_rsp(isp_pkg::ACT_PIN, 8'd0, 1'b0, 8'd0, isp_pkg::ST_OK);
               end else if (item.opcode == isp_pkg::OP_ENABLE) begin
                  r0 = isp_pkg::make_rsp(isp_pkg::ACT_PIN, 8'd0, 1'b1, 8'd0, isp_pkg::ST_OK);
               end else begin
                  r0 = isp_pkg::make_rsp(isp_pkg::ACT_SEND, frame_in[0], 1'b0, 8'd0,
                                         isp_pkg::ST_OK);
               end
               cnt = 2'd1;
            end
         end else if (item.opcode == isp_pkg::OP_BYTE_RX) begin
            if (busy_ff && phase_ff == isp_pkg::PH_XFER) begin
               frame_in[idx_ff] = item.rx_byte;
               if (idx_ff == 2'd2) begin
                  echo_in = item.rx_byte;
               end
               cnt = 2'd1;
               if (idx_ff != 2'd3) begin
                  idx_in = idx_ff + 2'd1;
                  r0 = isp_pkg::make_rsp(isp_pkg::ACT_SEND, frame_ff[idx_ff + 2'd1], 1'b0,
                                         8'd0, isp_pkg::ST_OK);
               end else begin
                  r0 = isp_pkg::make_rsp(isp_pkg::ACT_DONE, 8'd0, 1'b0, 8'd0, isp_pkg::ST_OK);
                  if ((polling_ff && item.rx_byte[0]) ||
                      (!polling_ff && (cmd_ff == isp_pkg::OP_ERASE ||
                                       cmd_ff == isp_pkg::OP_PAGE_WRITE ||
                                       cmd_ff == isp_pkg::OP_EEPROM_WRITE))) begin
                     // another busy poll
                     polling_in  = 1'b1;
                     frame_in[0] = isp_pkg::CMD_POLL;
                     frame_in[1] = 8'd0;
                     frame_in[2] = 8'd0;
                     frame_in[3] = 8'd0;
                     idx_in      = 2'd0;
                     r0 = isp_pkg::make_rsp(isp_pkg::ACT_SEND, isp_pkg::CMD_POLL, 1'b0,
                                            8'd0, isp_pkg::ST_OK);
                  end else if (!polling_ff && cmd_ff == isp_pkg::OP_ENABLE &&
                               echo_ff != isp_pkg::CMD_ENABLE2 && attempt_nx < limit) begin
                     attempt_in = attempt_nx;
                     phase_in   = isp_pkg::PH_EN_PULSE;
                     tick_in    = cfg.reset_pulse_ticks;
                     r0 = isp_pkg::make_rsp(isp_pkg::ACT_PIN, 8'd0, 1'b1, 8'd0,
                                            isp_pkg::ST_OK);
                  end else begin
                     busy_in    = 1'b0;
                     phase_in   = isp_pkg::PH_IDLE;
                     polling_in = 1'b0;
                     if (!polling_ff && cmd_ff == isp_pkg::OP_ENABLE) begin
                        if (echo_ff == isp_pkg::CMD_ENABLE2) begin
                           enabled_in = 1'b1;
                        end else begin
                           attempt_in = attempt_nx;
                           r0.status  = isp_pkg::ST_FAIL;
                        end
                     end else if (!polling_ff && (cmd_ff == isp_pkg::OP_SIGNATURE ||
                                                  cmd_ff == isp_pkg::OP_FLASH_READ ||
                                                  cmd_ff == isp_pkg::OP_EEPROM_READ)) begin
                        r0.read_data = item.rx_byte;
                     end
                  end
               end
            end
         end else if (item.opcode == isp_pkg::OP_TICK) begin
            if (busy_ff && in_wait) begin
               if (tick_ff > 10'd1) begin
                  tick_in = tick_ff - 10'd1;
               end else if (phase_ff == isp_pkg::PH_RESET_LOW) begin
                  tick_in    = 10'd0;
                  enabled_in = 1'b0;
                  busy_in    = 1'b0;
                  phase_in   = isp_pkg::PH_IDLE;
                  polling_in = 1'b0;
                  r0 = isp_pkg::make_rsp(isp_pkg::ACT_PIN, 8'd0, 1'b1, 8'd0, isp_pkg::ST_OK);
                  r1 = isp_pkg::make_rsp(isp_pkg::ACT_DONE, 8'd0, 1'b0, 8'd0, isp_pkg::ST_OK);
                  cnt = 2'd2;
               end else if (phase_ff == isp_pkg::PH_EN_PULSE) begin
                  phase_in = isp_pkg::PH_EN_SETTLE;
                  tick_in  = cfg.settle_ticks;
                  r0 = isp_pkg::make_rsp(isp_pkg::ACT_PIN, 8'd0, 1'b0, 8'd0, isp_pkg::ST_OK);
                  cnt = 2'd1;
               end else begin
                  tick_in     = 10'd0;
                  frame_in[0] = isp_pkg::CMD_PROG;
                  frame_in[1] = isp_pkg::CMD_ENABLE2;
                  frame_in[2] = 8'd0;
                  frame_in[3] = 8'd0;
                  idx_in      = 2'd0;
                  phase_in    = isp_pkg::PH_XFER;
                  r0 = isp_pkg::make_rsp(isp_pkg::ACT_SEND, isp_pkg::CMD_PROG, 1'b0, 8'd0,
                                         isp_pkg::ST_OK);
                  cnt = 2'd1;
               end
            end
         end
      end
      r0.programming_enabled = enabled_in;
      r1.programming_enabled = enabled_in;
      r0.last = (cnt == 2'd1);
      r1.last = 1'b1;
   end

   assign push.count  = cnt;
   assign push.first  = r0;
   assign push.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         phase_ff   <= isp_pkg::PH_IDLE;
         cmd_ff     <= isp_pkg::OP_RESET;
         idx_ff     <= 2'd0;
         echo_ff    <= 8'd0;
         attempt_ff <= 8'd0;
         tick_ff    <= 10'd0;
         polling_ff <= 1'b0;
         enabled_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         phase_ff   <= phase_in;
         cmd_ff     <= cmd_in;
         idx_ff     <= idx_in;
         echo_ff    <= echo_in;
         attempt_ff <= attempt_in;
         tick_ff    <= tick_in;
         polling_ff <= polling_in;
         enabled_ff <= enabled_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

endmodule

>>> hdl/isp_rsp_fifo.sv
module isp_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  isp_pkg::push_type push,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output isp_pkg::rsp_type  out_data
);

   isp_pkg::rsp_type entry_ff [4];
   logic [1:0]       wr_ff, wr_in;
   logic [1:0]       rd_ff, rd_in;
   logic [2:0]       count_ff, count_in;
   logic             pop;

   assign room      = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entry_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff + push.count;
      rd_in    = rd_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push.count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/isp_programming_sequencer.sv
// order: a request is registered, then decided once the response queue has room; the
//   decision pushes its first response and any second response into the queue together
// throughput: one request per cycle while the four-entry response queue has room
// reset: synchronous, active high; sequencer idle, programming mode off,
//   registers at 5 pulse ticks, 81 settle ticks, 20 enable attempts
module isp_programming_sequencer (
   input  logic        clock,
   input  logic        reset,
   isp_req_if.sink     req_chan,
   isp_rsp_if.source   rsp_chan,
   isp_csr_if.sink     csr_chan
);

   logic               in_valid_ff, in_valid_in;
   isp_pkg::req_type   in_item_ff;
   isp_pkg::req_type   req_item;
   isp_pkg::cfg_type   cfg_ff, cfg_in;
   isp_pkg::push_type  push;
   isp_pkg::rsp_type   rsp_data;
   logic               room;
   logic               go;
   logic               req_take;

   assign go       = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || go;
   assign req_take = req_chan.valid && req_chan.ready;
   assign in_valid_in = req_take || (in_valid_ff && !go);

   assign req_item.opcode     = req_chan.opcode;
   assign req_item.address    = req_chan.address;
   assign req_item.write_data = req_chan.write_data;
   assign req_item.rx_byte    = req_chan.rx_byte;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            isp_pkg::REG_RESET_PULSE: cfg_in.reset_pulse_ticks = csr_chan.reg_data;
            isp_pkg::REG_SETTLE:      cfg_in.settle_ticks      = csr_chan.reg_data;
            isp_pkg::REG_ATTEMPTS:    cfg_in.enable_attempts   = csr_chan.reg_data[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         cfg_ff.reset_pulse_ticks <= isp_pkg::RESET_PULSE_DEFAULT;
         cfg_ff.settle_ticks      <= isp_pkg::SETTLE_DEFAULT;
         cfg_ff.enable_attempts   <= isp_pkg::ATTEMPTS_DEFAULT;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   isp_seq_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .push  (push)
   );

   isp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.action              = rsp_data.action;
   assign rsp_chan.tx_byte             = rsp_data.tx_byte;
   assign rsp_chan.reset_level         = rsp_data.reset_level;
   assign rsp_chan.read_data           = rsp_data.read_data;
   assign rsp_chan.status              = rsp_data.status;
   assign rsp_chan.programming_enabled = rsp_data.programming_enabled;
   assign rsp_chan.last                = rsp_data.last;

endmodule

>>> tb/isp_sequencer_checker.sv
module isp_sequencer_checker
   import isp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   isp_req_if   req_chan,
   isp_rsp_if   rsp_chan,
   isp_csr_if   csr_chan,
   output int   fail_count,
   output int   outstanding,
   output int   request_count,
   output int   response_count
);

   timeunit 1ns;
   timeprecision 1ps;

   // register copies
   ticks_type  pulse_cfg;
   ticks_type  settle_cfg;
   logic [7:0] attempts_cfg;

   // sequencer state
   logic       seq_busy;
   phase_type  seq_phase;
   opcode_type active_op;
   logic [7:0] frame [FRAME_BYTES];
   logic [1:0] frame_pos;
   logic [7:0] echo;
   logic [7:0] tries;
   ticks_type  countdown;
   logic       polling;
   logic       prog_mode;

   rsp_type expected_rsps[$];
   rsp_type step_rsps[$];

   task automatic emit(action_type act, logic [7:0] tx, logic lvl, logic [7:0] rd,
                       status_type st);
      rsp_type r;
      r = '0;
      r.action      = act;
      r.tx_byte     = tx;
      r.reset_level = lvl;
      r.read_data   = rd;
      r.status      = st;
      step_rsps.push_back(r);
   endtask

   task automatic load_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
      frame[0]  = b0;
      frame[1]  = b1;
      frame[2]  = b2;
      frame[3]  = b3;
      frame_pos = 2'd0;
      seq_phase = PH_XFER;
   endtask

   task automatic complete(logic [7:0] rd, status_type st);
      seq_busy  = 1'b0;
      seq_phase = PH_IDLE;
      polling   = 1'b0;
      emit(ACT_DONE, 8'd0, 1'b0, rd, st);
   endtask

   task automatic begin_pulse();
      seq_phase = PH_EN_PULSE;
      countdown = pulse_cfg;
      emit(ACT_PIN, 8'd0, 1'b1, 8'd0, ST_OK);
   endtask

   task automatic start_poll();
      load_frame(CMD_POLL, 8'd0, 8'd0, 8'd0);
      emit(ACT_SEND, CMD_POLL, 1'b0, 8'd0, ST_OK);
   endtask

   task automatic end_of_frame(logic [7:0] rx);
      logic [7:0] limit;
      limit = (attempts_cfg == 8'd0) ? 8'd1 : attempts_cfg;
      if (polling) begin
         if (!rx[0]) begin
            complete(8'd0, ST_OK);
         end else begin
            start_poll();
         end
      end else if (active_op == OP_ENABLE) begin
         if (echo == CMD_ENABLE2) begin
            prog_mode = 1'b1;
            complete(8'd0, ST_OK);
         end else begin
            if (tries < 8'd255) begin
               tries++;
            end
            if (tries >= limit) begin
               complete(8'd0, ST_FAIL);
            end else begin
               begin_pulse();
            end
         end
      end else begin
         case (active_op)
            OP_ERASE, OP_PAGE_WRITE, OP_EEPROM_WRITE: begin
               polling = 1'b1;
               start_poll();
            end
            OP_SIGNATURE, OP_FLASH_READ, OP_EEPROM_READ: complete(frame[3], ST_OK);
            default: complete(8'd0, ST_OK);
         endcase
      end
   endtask

   task automatic predict_step(opcode_type op, logic [15:0] addr, logic [7:0] wd,
                               logic [7:0] rx);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] sig_index;
      hi        = {1'b0, addr[15:9]};
      lo        = addr[8:1];
      sig_index = 8'(addr[7:0] % 8'd3);
      step_rsps.delete();
      if (op <= OP_EEPROM_WRITE) begin
         if (seq_busy) begin
            emit(ACT_DONE, 8'd0, 1'b0, 8'd0, ST_REJECT);
         end else begin
            seq_busy  = 1'b1;
            active_op = op;
            polling   = 1'b0;
            case (op)
               OP_RESET: begin
                  seq_phase = PH_RESET_LOW;
                  countdown = pulse_cfg;
                  emit(ACT_PIN, 8'd0, 1'b0, 8'd0, ST_OK);
               end
               OP_ENABLE: begin
                  tries = 8'd0;
                  begin_pulse();
               end
               OP_SIGNATURE:   load_frame(CMD_SIG, 8'd0, sig_index, 8'd0);
               OP_ERASE:       load_frame(CMD_PROG, CMD_ERASE2, 8'd0, 8'd0);
               OP_FLASH_READ:  load_frame(addr[0] ? CMD_RD_HI : CMD_RD_LO, hi, lo, 8'd0);
               OP_FLASH_LOAD:  load_frame(addr[0] ? CMD_LD_HI : CMD_LD_LO, hi, lo, wd);
               OP_PAGE_WRITE:  load_frame(CMD_PAGE, hi, lo, 8'd0);
               OP_EEPROM_READ: load_frame(CMD_EE_RD, 8'd0, addr[7:0], 8'd0);
               default:        load_frame(CMD_EE_WR, 8'd0, addr[7:0], wd);
            endcase
            if (op >= OP_SIGNATURE) begin
               emit(ACT_SEND, frame[0], 1'b0, 8'd0, ST_OK);
            end
         end
      end else if (op == OP_BYTE_RX) begin
         if (seq_busy && seq_phase == PH_XFER) begin
            frame[frame_pos] = rx;
            if (frame_pos == 2'd2) begin
               echo = rx;
            end
            if (frame_pos < 2'd3) begin
               frame_pos++;
               emit(ACT_SEND, frame[frame_pos], 1'b0, 8'd0, ST_OK);
            end else begin
               end_of_frame(rx);
            end
         end
      end else if (op == OP_TICK) begin
         if (seq_busy && (seq_phase == PH_RESET_LOW || seq_phase == PH_EN_PULSE ||
                          seq_phase == PH_EN_SETTLE)) begin
            if (countdown > 10'd1) begin
               countdown--;
            end else if (seq_phase == PH_RESET_LOW) begin
               countdown = 10'd0;
               prog_mode = 1'b0;
               emit(ACT_PIN, 8'd0, 1'b1, 8'd0, ST_OK);
               complete(8'd0, ST_OK);
            end else if (seq_phase == PH_EN_PULSE) begin
               seq_phase = PH_EN_SETTLE;
               countdown = settle_cfg;
               emit(ACT_PIN, 8'd0, 1'b0, 8'd0, ST_OK);
            end else begin
               countdown = 10'd0;
               load_frame(CMD_PROG, CMD_ENABLE2, 8'd0, 8'd0);
               emit(ACT_SEND, frame[0], 1'b0, 8'd0, ST_OK);
            end
         end
      end
      foreach (step_rsps[i]) begin
         step_rsps[i].programming_enabled = prog_mode;
         step_rsps[i].last                = (i == step_rsps.size() - 1);
         expected_rsps.push_back(step_rsps[i]);
      end
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         pulse_cfg    = RESET_PULSE_DEFAULT;
         settle_cfg   = SETTLE_DEFAULT;
         attempts_cfg = ATTEMPTS_DEFAULT;
         seq_busy     = 1'b0;
         seq_phase    = PH_IDLE;
         active_op    = OP_RESET;
         foreach (frame[i]) begin
            frame[i] = 8'd0;
         end
         frame_pos    = 2'd0;
         echo         = 8'd0;
         tries        = 8'd0;
         countdown    = 10'd0;
         polling      = 1'b0;
         prog_mode    = 1'b0;
         expected_rsps.delete();
         fail_count     = 0;
         request_count  = 0;
         response_count = 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.reg_index)
               REG_RESET_PULSE: pulse_cfg = csr_chan.reg_data;
               REG_SETTLE:      settle_cfg = csr_chan.reg_data;
               REG_ATTEMPTS:    attempts_cfg = csr_chan.reg_data[7:0];
               default: ;
            endcase
         end
         // responses first: none can come from a request taken at this edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            response_count++;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response: action %0h tx_byte %0h status %0h",
                      rsp_chan.action, rsp_chan.tx_byte, rsp_chan.status);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("action", want.action, rsp_chan.action);
               check_field("tx_byte", want.tx_byte, rsp_chan.tx_byte);
               check_field("reset_level", want.reset_level, rsp_chan.reset_level);
               check_field("read_data", want.read_data, rsp_chan.read_data);
               check_field("status", want.status, rsp_chan.status);
               check_field("programming_enabled", want.programming_enabled,
                           rsp_chan.programming_enabled);
               check_field("last", want.last, rsp_chan.last);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            request_count++;
            predict_step(req_chan.opcode, req_chan.address, req_chan.write_data,
                         req_chan.rx_byte);
         end
      end
      outstanding = expected_rsps.size();
   end

endmodule

>>> tb/isp_programming_sequencer_test.sv
module isp_programming_sequencer_test;

   timeunit 1ns;
   timeprecision 1ps;

   import isp_pkg::*;

   localparam int            LIMIT_CYCLES  = 1_000_000;
   localparam int            LONG_HOLD     = 300;
   localparam int            DRAIN_CYCLES  = 10;
   localparam opcode_type    OP_UNUSED_MAX = 4'd15;
   localparam reg_index_type REG_SPARE     = 2'd3;

   logic clock;
   logic reset;

   isp_req_if req_chan();
   isp_rsp_if rsp_chan();
   isp_csr_if csr_chan();

   int fail_count;
   int outstanding;
   int request_count;
   int response_count;

   int         cycles;
   bit         quiet;
   bit         long_hold_req;
   int         work_items;
   int         settings_used;
   ticks_type  pulse_now;
   ticks_type  settle_now;
   logic [7:0] attempts_now;

   isp_programming_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   isp_sequencer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .request_count  (request_count),
      .response_count (response_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("isp_programming_sequencer_test failed");
         $finish;
      end
   end

   // response side: random stall bursts, plus one long hold on request
   initial begin : rsp_side
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic int eff_ticks(ticks_type t);
      return (t == 10'd0) ? 1 : int'(t);
   endfunction

   function automatic int eff_attempts(logic [7:0] a);
      return (a == 8'd0) ? 1 : int'(a);
   endfunction

   task automatic send_req(opcode_type op, logic [15:0] addr, logic [7:0] wd, logic [7:0] rx);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.address    <= addr;
      req_chan.write_data <= wd;
      req_chan.rx_byte    <= rx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_work(opcode_type op, logic [7:0] rx);
      send_req(op, 16'($urandom), 8'($urandom), rx);
      work_items++;
   endtask

   task automatic stray_request(bit in_xfer, bit while_busy);
      case ($urandom_range(0, 2))
         0: begin
            if (while_busy) begin
               send_req(opcode_type'($urandom_range(OP_RESET, OP_EEPROM_WRITE)),
                        16'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               send_req(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
            end
         end
         1: send_req(in_xfer ? OP_TICK : OP_BYTE_RX, 16'($urandom), 8'($urandom),
                     8'($urandom));
         default: send_req(opcode_type'($urandom_range(OP_TICK + 1, OP_UNUSED_MAX)),
                           16'($urandom), 8'($urandom), 8'($urandom));
      endcase
   endtask

   task automatic xfer_frame(logic [7:0] third, logic [7:0] fourth, bit noisy);
      logic [7:0] rx_seq [4];
      rx_seq = '{8'($urandom), 8'($urandom), third, fourth};
      for (int i = 0; i < 4; i++) begin
         if (noisy && $urandom_range(0, 4) == 0) begin
            stray_request(1'b1, 1'b1);
         end
         send_work(OP_BYTE_RX, rx_seq[i]);
      end
   endtask

   task automatic tick_wait(int n, bit noisy);
      repeat (n) begin
         if (noisy && $urandom_range(0, 4) == 0) begin
            stray_request(1'b0, 1'b1);
         end
         send_work(OP_TICK, 8'($urandom));
      end
   endtask

   task automatic poll_frames(int busy_polls, bit noisy);
      repeat (busy_polls) xfer_frame(8'($urandom), 8'($urandom) | 8'h01, noisy);
      xfer_frame(8'($urandom), 8'($urandom) & 8'hfe, noisy);
   endtask

   task automatic run_enable(bit noisy, int success_at);
      int         limit;
      logic [7:0] echo;
      limit = eff_attempts(attempts_now);
      send_work(OP_ENABLE, 8'($urandom));
      for (int attempt = 1; attempt <= limit; attempt++) begin
         tick_wait(eff_ticks(pulse_now), noisy);
         tick_wait(eff_ticks(settle_now), noisy);
         if (attempt == success_at) begin
            echo = CMD_ENABLE2;
         end else begin
            echo = 8'($urandom);
            if (echo == CMD_ENABLE2) begin
               echo = ~echo;
            end
         end
         xfer_frame(echo, 8'($urandom), noisy);
         if (attempt == success_at) begin
            break;
         end
      end
   endtask

   task automatic run_command(opcode_type op, bit noisy);
      int limit;
      limit = eff_attempts(attempts_now);
      case (op)
         OP_RESET: begin
            send_work(op, 8'($urandom));
            tick_wait(eff_ticks(pulse_now), noisy);
         end
         OP_ENABLE: begin
            run_enable(noisy, (limit > 3) ? $urandom_range(1, 4) : $urandom_range(1, limit + 1));
         end
         OP_ERASE, OP_PAGE_WRITE, OP_EEPROM_WRITE: begin
            send_work(op, 8'($urandom));
            xfer_frame(8'($urandom), 8'($urandom), noisy);
            poll_frames($urandom_range(0, 3), noisy);
         end
         default: begin
            send_work(op, 8'($urandom));
            xfer_frame(8'($urandom), 8'($urandom), noisy);
         end
      endcase
   endtask

   task automatic wait_drained(int extra_cycles);
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (extra_cycles) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [9:0] data);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.reg_data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(ticks_type pulse, ticks_type settle, logic [9:0] attempts);
      wait_drained(DRAIN_CYCLES);
      write_reg(REG_RESET_PULSE, pulse);
      write_reg(REG_SETTLE, settle);
      write_reg(REG_ATTEMPTS, attempts);
      pulse_now    = pulse;
      settle_now   = settle;
      attempts_now = attempts[7:0];
      settings_used++;
   endtask

   task automatic random_phase(int n, bit hold_midway, bit drain_midway);
      int         goal;
      int         r;
      bit         midway_done;
      opcode_type op;
      goal        = work_items + n;
      midway_done = 1'b0;
      while (work_items < goal) begin
         if (!midway_done && work_items >= goal - n / 2) begin
            midway_done = 1'b1;
            if (hold_midway) begin
               long_hold_req = 1'b1;
            end
            if (drain_midway) begin
               wait_drained(1);
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            stray_request($urandom_range(0, 1), 1'b0);
         end
         r = $urandom_range(0, 99);
         if (r < 8) begin
            op = OP_RESET;
         end else if (r < 20) begin
            op = OP_ENABLE;
         end else begin
            op = opcode_type'($urandom_range(OP_SIGNATURE, OP_EEPROM_WRITE));
         end
         run_command(op, $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      reset               = 1'b1;
      quiet               = 1'b0;
      long_hold_req       = 1'b0;
      work_items          = 0;
      settings_used       = 0;
      pulse_now           = RESET_PULSE_DEFAULT;
      settle_now          = SETTLE_DEFAULT;
      attempts_now        = ATTEMPTS_DEFAULT;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = OP_RESET;
      req_chan.address    = 16'd0;
      req_chan.write_data = 8'd0;
      req_chan.rx_byte    = 8'd0;
      csr_chan.valid      = 1'b0;
      csr_chan.reg_index  = REG_RESET_PULSE;
      csr_chan.reg_data   = 10'd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      apply_setting(10'd1, 10'd1, 10'd2);
      send_req(OP_BYTE_RX, 16'hffff, 8'hff, 8'hff);
      send_req(OP_TICK, 16'h0000, 8'h00, 8'h00);
      send_req(OP_UNUSED_MAX, 16'hffff, 8'hff, 8'hff);
      send_req(OP_FLASH_READ, 16'hffff, 8'h00, 8'h00);
      send_req(OP_BYTE_RX, 16'h0000, 8'h00, 8'h00);
      send_req(OP_BYTE_RX, 16'h0000, 8'h00, 8'hff);
      send_req(OP_EEPROM_WRITE, 16'hffff, 8'hff, 8'hff);
      send_req(OP_BYTE_RX, 16'h0000, 8'h00, 8'h55);
      send_req(OP_BYTE_RX, 16'h0000, 8'h00, 8'haa);
      send_req(OP_RESET, 16'h0000, 8'h00, 8'h00);
      send_req(OP_TICK, 16'h0000, 8'h00, 8'h00);
      run_enable(1'b0, 2);

      // random
      random_phase(350, 1'b0, 1'b0);
      apply_setting(10'd0, 10'd0, 10'd0);
      write_reg(REG_SPARE, 10'($urandom));
      random_phase(200, 1'b0, 1'b0);
      apply_setting(10'd3, 10'd5, 10'd3);
      random_phase(400, 1'b1, 1'b0);

      // register extremes
      apply_setting(10'd1, 10'd1, 10'h3ff);
      run_enable(1'b0, 3);
      apply_setting(10'd100, 10'd60, 10'd1);
      run_enable(1'b0, 2);
      run_command(OP_RESET, 1'b0);

      apply_setting(10'd2, 10'd4, 10'd4);
      random_phase(300, 1'b0, 1'b1);
      quiet = 1'b1;
      random_phase(150, 1'b0, 1'b0);
      wait_drained(DRAIN_CYCLES);

      $display("covered %0d requests and %0d responses over %0d register settings",
               request_count, response_count, settings_used);
      $display("incl. enable retries to exhaustion, busy polls, rejects and a long stall");
      if (fail_count == 0) begin
         $display("isp_programming_sequencer_test passed");
      end else begin
         $display("isp_programming_sequencer_test failed");
      end
      $finish;
   end

endmodule
